/* design/array_list_insert_remove_unit_assert.svh */
// assertion macros shared by the list unit
`ifndef ARRAY_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define ARRAY_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define ALRU_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by i_clk, off during reset
`define ALRU_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/alru_pkg.sv */
`default_nettype none

package alru_pkg;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 5;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        K_INS_END   = 3'd0,
        K_INS_AT    = 3'd1,
        K_INS_FRONT = 3'd2,
        K_REM_END   = 3'd3,
        K_REM_AT    = 3'd4,
        K_REM_FRONT = 3'd5,
        K_READ      = 3'd6,
        K_CLEAR     = 3'd7
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_RD_WAIT,
        S_RESP
    } t_state;

    // memory port strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // finished request handed to the output stage
    typedef struct packed {
        logic    valid;
        t_status status;
        logic    rd_ok;
    } t_rsp;

endpackage

`default_nettype wire

/* design/alru_mem.sv */
`default_nettype none

module alru_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire alru_pkg::t_mem_ctl   i_ctl,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [DW-1:0]        i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output      logic [DW-1:0]        o_rdata
);
    import alru_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/alru_ctrl.sv */
`default_nettype none
`include "array_list_insert_remove_unit_assert.svh"

module alru_ctrl #(
    parameter int CAPACITY = 16,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output      logic                        o_req_ready,
    input  wire alru_pkg::t_kind             i_kind,
    input  wire logic [alru_pkg::POS_W-1:0]  i_position,
    input  wire logic [alru_pkg::VAL_W-1:0]  i_value,
    output      alru_pkg::t_rsp              o_rsp,
    input  wire logic                        i_rsp_ack,
    output      logic [CW-1:0]               o_count,
    output      alru_pkg::t_mem_ctl          o_mem,
    output      logic [AW-1:0]               o_waddr,
    output      logic [AW-1:0]               o_raddr,
    output      logic [alru_pkg::VAL_W-1:0]  o_wdata,
    input  wire logic [alru_pkg::VAL_W-1:0]  i_rdata
);
    import alru_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_end;
    logic [VAL_W-1:0]    r_value;
    t_status             r_status;
    logic                r_rd_ok;

    logic [CMPW-1:0]     w_cnt, w_pos, w_at;
    logic                w_is_ins, w_is_rem, w_is_read, w_is_clear;
    t_status             w_status;
    logic                w_take;
    logic [AW-1:0]       w_step;
    logic                w_done;

    // request decode
    assign w_cnt = CMPW'(r_count);
    assign w_pos = CMPW'(i_position);

    always_comb begin
        w_is_ins   = 1'b0;
        w_is_rem   = 1'b0;
        w_is_read  = 1'b0;
        w_is_clear = 1'b0;
        w_at       = w_pos;
        unique case (i_kind)
            K_INS_END: begin
                w_is_ins = 1'b1;
                w_at     = w_cnt;
            end
            K_INS_AT: begin
                w_is_ins = 1'b1;
            end
            K_INS_FRONT: begin
                w_is_ins = 1'b1;
                w_at     = '0;
            end
            K_REM_END: begin
                w_is_rem = 1'b1;
                w_at     = w_cnt - CMPW'(1);
            end
            K_REM_AT: begin
                w_is_rem = 1'b1;
            end
            K_REM_FRONT: begin
                w_is_rem = 1'b1;
                w_at     = '0;
            end
            K_READ: begin
                w_is_read = 1'b1;
            end
            K_CLEAR: begin
                w_is_clear = 1'b1;
            end
            default: begin
                w_is_clear = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_status = ST_OK;
        if (w_is_ins) begin
            if (w_cnt == CMPW'(CAPACITY)) begin
                w_status = ST_FULL;
            end else if (w_at > w_cnt) begin
                w_status = ST_RANGE;
            end
        end else if (w_is_rem || w_is_read) begin
            if (w_cnt == '0) begin
                w_status = ST_EMPTY;
            end else if (w_at >= w_cnt) begin
                w_status = ST_RANGE;
            end
        end
    end

    assign w_take = (r_state == S_IDLE) && i_req_valid;

    // shared index unit: one step and one compare per cycle
    assign w_step = ((r_state == S_INS_RD) || (r_state == S_INS_WR))
                    ? r_idx - AW'(1) : r_idx + AW'(1);
    assign w_done = (r_idx == r_end);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (w_status != ST_OK || w_is_clear) begin
                        n_state = S_RESP;
                    end else if (w_is_ins) begin
                        n_state = S_INS_RD;
                    end else if (w_is_rem) begin
                        n_state = S_REM_RD;
                    end else begin
                        n_state = S_RD_WAIT;
                    end
                end
            end
            S_INS_RD:  n_state = w_done ? S_RESP : S_INS_WR;
            S_INS_WR:  n_state = S_INS_RD;
            S_REM_RD:  n_state = w_done ? S_RESP : S_REM_WR;
            S_REM_WR:  n_state = S_REM_RD;
            S_RD_WAIT: n_state = S_RESP;
            S_RESP:    n_state = i_rsp_ack ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_mem       = '0;
        o_raddr     = w_step;
        o_waddr     = r_idx;
        o_wdata     = i_rdata;
        unique case (r_state)
            S_IDLE: begin
                o_raddr  = AW'(w_at);
                o_mem.re = i_req_valid && w_is_read && (w_status == ST_OK);
            end
            S_INS_RD: begin
                o_mem.re = !w_done;
                o_mem.we = w_done;
                o_wdata  = r_value;
            end
            S_INS_WR, S_REM_WR: begin
                o_mem.we = 1'b1;
            end
            S_REM_RD: begin
                o_mem.re = !w_done;
            end
            S_RD_WAIT, S_RESP: begin
                o_mem = '0;
            end
            default: begin
                o_mem = '0;
            end
        endcase
        o_rsp.valid  = (r_state == S_RESP);
        o_rsp.status = r_status;
        o_rsp.rd_ok  = r_rd_ok;
        o_count      = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_take && w_is_clear) begin
                r_count <= '0;
            end else if (r_state == S_INS_RD && w_done) begin
                r_count <= r_count + CW'(1);
            end else if (r_state == S_REM_RD && w_done) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_value  <= i_value;
            r_status <= w_status;
            r_rd_ok  <= w_is_read && (w_status == ST_OK);
            if (w_is_ins) begin
                r_idx <= AW'(w_cnt);
                r_end <= AW'(w_at);
            end else begin
                r_idx <= AW'(w_at);
                r_end <= AW'(w_cnt - CMPW'(1));
            end
        end else if (r_state == S_INS_WR || r_state == S_REM_WR) begin
            r_idx <= w_step;
        end
    end

    `ALRU_CHECK(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `ALRU_CHECK(a_ins_order, r_state == S_INS_RD, r_idx >= r_end, "insert index passed its end")
    `ALRU_CHECK(a_rem_order, r_state == S_REM_RD, r_idx <= r_end, "remove index passed its end")
    `ALRU_CHECK_NEXT(a_rem_count, r_state == S_REM_RD && w_done,
        r_count == $past(r_count) - CW'(1), "remove did not drop count")
    `ALRU_CHECK_NEXT(a_clear, w_take && w_is_clear, r_count == '0, "clear left entries")

endmodule

`default_nettype wire

/* design/array_list_insert_remove_unit.sv */
// result path: clear and refused requests pass S_RESP into the output register;
//   read adds S_RD_WAIT; insert and remove add a last read state, plus a read and
//   a write state per moved entry; a new request is taken only once the last result
//   has left S_RESP, so a stalled result holds off new requests
// reset: synchronous active low i_rst_n empties the list and idles the sequencer;
//   list storage is not cleared and no clearing pass runs
`default_nettype none

module array_list_insert_remove_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request stream
    input  wire logic                              i_s_tvalid,
    output      logic                              o_s_tready,
    // tdata: position [4:0], value [36:5], zero pad [39:37]
    input  wire logic [alru_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: kind [2:0]
    input  wire logic [alru_pkg::KIND_W-1:0]       i_s_tuser,
    // result stream
    output      logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: status [1:0], count_now [6:2], read_value [38:7], zero pad [39]
    output      logic [alru_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import alru_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // request fields unpacked from the stream
    t_kind               w_kind;
    logic [POS_W-1:0]    w_position;
    logic [VAL_W-1:0]    w_value;

    // sequencer to output stage
    t_rsp                w_rsp;
    logic                w_rsp_ack;
    logic [CW-1:0]       w_count;

    // memory port
    t_mem_ctl            w_mem;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [VAL_W-1:0]    w_wdata, w_rdata;

    // result fields
    logic [CNT_W-1:0]    w_count_now;
    logic [VAL_W-1:0]    w_read_value;

    // output register
    logic                         r_m_valid;
    logic [OUT_TDATA_W-1:0]       r_m_data;

    assign w_kind     = t_kind'(i_s_tuser);
    assign w_position = i_s_tdata[POS_W-1:0];
    assign w_value    = i_s_tdata[POS_W +: VAL_W];

    // sequencer with the shared index step/compare unit
    alru_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_kind      (w_kind),
        .i_position  (w_position),
        .i_value     (w_value),
        .o_rsp       (w_rsp),
        .i_rsp_ack   (w_rsp_ack),
        .o_count     (w_count),
        .o_mem       (w_mem),
        .o_waddr     (w_waddr),
        .o_raddr     (w_raddr),
        .o_wdata     (w_wdata),
        .i_rdata     (w_rdata)
    );

    // list storage, one write and one registered read per cycle
    alru_mem #(
        .DEPTH (CAPACITY),
        .DW    (VAL_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // finished request moves into the output register when it is free or draining
    assign w_rsp_ack = w_rsp.valid && (!r_m_valid || i_m_tready);

    // count_now is the low bits of the count; read data only on a good read
    assign w_count_now  = CNT_W'(w_count);
    assign w_read_value = w_rsp.rd_ok ? w_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_rsp_ack) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_ack) begin
            r_m_data <= OUT_TDATA_W'({w_read_value, w_count_now, w_rsp.status});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

/* bench/array_list_insert_remove_unit_tb.sv */
`timescale 1ns / 1ps

module array_list_insert_remove_unit_tb;

    import alru_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP     = 25;

    // one result as the block should report it
    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count_now;
        logic [VAL_W-1:0]   read_value;
    } t_list_result;

    // block ports
    logic                    i_clk;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // tdata: position [4:0], value [36:5], zero pad [39:37]
    logic [IN_TDATA_W-1:0]   i_s_tdata  = '0;
    // tuser: kind [2:0]
    logic [KIND_W-1:0]       i_s_tuser  = K_INS_END;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // tdata: status [1:0], count_now [6:2], read_value [38:7], zero pad [39]
    logic [OUT_TDATA_W-1:0]  o_m_tdata;

    // shadow copy of the list, updated as each request is accepted
    logic [VAL_W-1:0]  list_mem [LIST_CAPACITY];
    int                list_len = 0;
    t_list_result      pending_results [$];

    // idling knobs, changed per phase by the test tasks
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int recv_hold_cycles = 0;
    int recv_gap_left    = 0;

    // bookkeeping
    int mismatch_count = 0;
    int request_count  = 0;
    int result_count   = 0;
    int cycle_count    = 0;
    int peak_len       = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    array_list_insert_remove_unit #(
        .CAPACITY(LIST_CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // apply one request to the shadow list and return what the block must answer
    function automatic t_list_result list_apply_request(t_kind op, logic [POS_W-1:0] pos,
                                                        logic [VAL_W-1:0] val);
        t_list_result res;
        int at;
        int i;
        res.status     = ST_OK;
        res.read_value = '0;
        case (op)
            K_INS_END, K_INS_AT, K_INS_FRONT: begin
                // full check wins over the position check
                if (list_len >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    at = (op == K_INS_END) ? list_len : (op == K_INS_FRONT) ? 0 : int'(pos);
                    if (at > list_len) begin
                        res.status = ST_RANGE;
                    end else begin
                        // open a hole at the position, later entries move right
                        for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
                        list_mem[at] = val;
                        list_len++;
                    end
                end
            end
            K_REM_END, K_REM_AT, K_REM_FRONT, K_READ: begin
                // empty check wins over the position check
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    at = (op == K_REM_END) ? list_len - 1 : (op == K_REM_FRONT) ? 0 : int'(pos);
                    if (at >= list_len) begin
                        res.status = ST_RANGE;
                    end else if (op == K_READ) begin
                        res.read_value = list_mem[at];
                    end else begin
                        // close the hole, later entries move left
                        for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                        list_len--;
                    end
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.count_now = list_len[CNT_W-1:0];
        status_tally[res.status]++;
        if (list_len > peak_len) peak_len = list_len;
        return res;
    endfunction

    task automatic pause_sender(input int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // offer one request, wait for the handshake, then maybe idle for a while
    task automatic send_request(input t_kind op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, val, pos};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(list_apply_request(op, pos, val));
        request_count++;
        if ($urandom_range(0, 99) < send_idle_pct) pause_sender(pick_gap_len());
    endtask

    task automatic wait_until_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // extremes mixed with plain random words
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // position that mostly lands inside the list, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(t_kind op);
        if ($urandom_range(0, 99) < 85) begin
            if (op == K_INS_AT || op == K_INS_END || op == K_INS_FRONT) begin
                return POS_W'($urandom_range(0, list_len));
            end else if (list_len > 0) begin
                return POS_W'($urandom_range(0, list_len - 1));
            end
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    // one random request; ins_pct steers the list toward full or toward empty
    task automatic send_random_request(input int ins_pct);
        t_kind op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            op = K_CLEAR;
        end else if (r < 2 + ins_pct) begin
            op = t_kind'($urandom_range(0, 2));
        end else begin
            op = t_kind'($urandom_range(3, 6));
        end
        send_request(op, pick_position(op), pick_value());
    endtask

    // every refusal an empty list can give
    task automatic test_empty_list_refusals();
        send_request(K_REM_END,   5'd0,  32'h1234_5678);
        send_request(K_REM_AT,    5'd0,  32'h0);
        send_request(K_REM_FRONT, 5'd0,  32'h0);
        send_request(K_READ,      5'd0,  32'h0);
        send_request(K_READ,      5'd16, 32'h0);
        send_request(K_INS_AT,    5'd1,  32'hdead_beef);
        pause_sender(1);
    endtask

    // value extremes, every kind and the position edges on a short list
    task automatic test_edge_values();
        send_request(K_INS_END,   5'd9,  32'h7fff_ffff);
        send_request(K_INS_FRONT, 5'd31, 32'h8000_0000);
        send_request(K_INS_AT,    5'd1,  32'hffff_ffff);
        send_request(K_INS_AT,    5'd3,  32'h0000_0000);   // position equal to count appends
        send_request(K_INS_AT,    5'd5,  32'h5555_5555);   // past the end
        send_request(K_READ,      5'd0,  32'h0);
        send_request(K_READ,      5'd1,  32'h0);
        send_request(K_READ,      5'd2,  32'h0);
        send_request(K_READ,      5'd3,  32'h0);
        send_request(K_READ,      5'd4,  32'h0);           // one past the last entry
        send_request(K_REM_AT,    5'd31, 32'h0);
        send_request(K_REM_AT,    5'd1,  32'h0);
        send_request(K_REM_FRONT, 5'd7,  32'h0);
        send_request(K_REM_END,   5'd0,  32'h0);
        send_request(K_CLEAR,     5'd0,  32'h0);
        send_request(K_CLEAR,     5'd31, 32'hffff_ffff);   // clear an empty list
        pause_sender(1);
    endtask

    // fill to the top, then knock on the full list from every side
    task automatic test_fill_to_capacity();
        t_kind op;
        send_idle_pct = 20;
        send_request(K_CLEAR, 5'd0, 32'h0);
        while (list_len < LIST_CAPACITY) begin
            op = t_kind'($urandom_range(0, 2));
            send_request(op, POS_W'($urandom_range(0, list_len)), pick_value());
        end
        send_request(K_INS_END,   5'd0,  32'h1111_1111);
        send_request(K_INS_AT,    5'd16, 32'h2222_2222);
        send_request(K_INS_AT,    5'd31, 32'h3333_3333);   // full beats bad position
        send_request(K_INS_FRONT, 5'd0,  32'h4444_4444);
        send_request(K_READ,      5'd15, 32'h0);
        send_request(K_READ,      5'd16, 32'h0);
        send_request(K_REM_AT,    5'd15, 32'h0);
        send_request(K_INS_AT,    5'd15, 32'h8000_0001);
        send_request(K_REM_AT,    5'd0,  32'h0);           // longest left shift
        send_request(K_INS_FRONT, 5'd0,  32'h7fff_fffe);   // longest right shift
        pause_sender(1);
        send_idle_pct = 0;
    endtask

    // bulk random traffic, swinging between filling and draining phases
    task automatic test_random_traffic();
        int round;
        int burst;
        int n;
        int ins_pct;
        for (round = 0; round < 8; round++) begin
            // first round runs flat out on both sides
            case (round % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 30; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 35; end
                default: begin send_idle_pct = 40; recv_idle_pct = 40; end
            endcase
            if (round == 7) begin
                send_idle_pct = 70;
                recv_idle_pct = 70;
            end
            for (burst = 0; burst < 6; burst++) begin
                ins_pct = (burst % 3 == 0) ? 78 : (burst % 3 == 1) ? 22 : 48;
                for (n = 0; n < 38; n++) send_random_request(ins_pct);
            end
        end
        pause_sender(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        int n;
        send_idle_pct    = 0;
        recv_hold_cycles = 300;
        for (n = 0; n < 40; n++) send_random_request(70);
        pause_sender(1);
    endtask

    // sender waits for every outstanding result before going on
    task automatic test_pause_until_drained();
        int n;
        send_idle_pct = 10;
        recv_idle_pct = 20;
        for (n = 0; n < 20; n++) send_random_request(60);
        pause_sender(1);
        wait_until_drained();
        for (n = 0; n < 20; n++) send_random_request(30);
        pause_sender(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                     $time, result_count, field, got, want);
        end
        mismatch_count++;
    endtask

    // receiver ready: long hold-off first, then random gaps
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            recv_hold_cycles--;
        end else if (recv_gap_left > 0) begin
            i_m_tready <= 1'b0;
            recv_gap_left--;
        end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            i_m_tready <= 1'b0;
            recv_gap_left = pick_gap_len() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", o_m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", 40'(o_m_tdata[1:0]), 40'(want.status));
                if (o_m_tdata[6:2] !== want.count_now)
                    report_mismatch("count_now", 40'(o_m_tdata[6:2]), 40'(want.count_now));
                if (o_m_tdata[38:7] !== want.read_value)
                    report_mismatch("read_value", 40'(o_m_tdata[38:7]),
                                    40'(want.read_value));
                if (o_m_tdata[39] !== 1'b0)
                    report_mismatch("pad bit", 40'(o_m_tdata[39]), '0);
            end
            result_count++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // reset held low at the start, once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list_refusals();
        test_edge_values();
        test_fill_to_capacity();
        test_random_traffic();
        test_result_backpressure();
        test_pause_until_drained();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests / %0d results, list depth peaked at %0d",
                 request_count, result_count, peak_len);
        $display("status mix: ok %0d, full %0d, empty %0d, bad position %0d",
                 status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_EMPTY], status_tally[ST_RANGE]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, pending_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
